/* sv/ppcu_pkg.sv */
package ppcu_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int PIXEL_BITS  = 64;

    localparam int NUM_CH      = 4;
    localparam int CH_W        = 16;
    localparam int PIX_W       = 64;
    localparam int SHIFT_W     = 6;
    localparam int SHIFT_SET_W = NUM_CH * SHIFT_W;
    localparam int MODE_W      = 2;
    localparam int SEL_W       = 2;
    localparam int TIDX_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // bits of the input word that belong to the pixel
    localparam logic [PIX_W-1:0] PIX_KEEP = {PIX_W{1'b1}} >> (PIX_W - PIXEL_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MASK_CH0,
        REG_MASK_CH1,
        REG_MASK_CH2,
        REG_MASK_CH3,
        REG_SHIFT_SET,
        REG_CHANNEL_MODE
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ONE,
        MODE_TWO,
        MODE_FOUR
    } chan_mode_t;

    typedef enum logic {
        FUNC_UNPACK,
        FUNC_WRITE
    } func_t;

    // decoded request held in the queue between front and back
    typedef struct packed {
        logic                           is_write;
        logic                           wr_ok;
        logic [SEL_W-1:0]               wr_sel;
        logic [TBL_AW-1:0]              wr_addr;
        logic [CH_W-1:0]                wr_value;
        logic [NUM_CH-1:0][TBL_AW-1:0]  rd_idx;
        logic [NUM_CH-1:0]              ch_ok;
        logic                           err;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* sv/ppcu_front.sv */
module ppcu_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ppcu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppcu_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             func,
    input  logic [ppcu_pkg::PIX_W-1:0]       pixel,
    input  logic [ppcu_pkg::SEL_W-1:0]       table_select,
    input  logic [ppcu_pkg::TIDX_W-1:0]      table_index,
    input  logic [ppcu_pkg::CH_W-1:0]        table_value,
    input  ppcu_pkg::q_status_t              q_status,
    output logic                             q_push,
    output ppcu_pkg::op_t                    q_op
);
    import ppcu_pkg::*;

    logic [PIX_W-1:0]       mask_reg [NUM_CH];
    logic [SHIFT_SET_W-1:0] shift_set_reg;
    logic [MODE_W-1:0]      mode_reg;

    logic [PIX_W-1:0]              px;
    logic [NUM_CH-1:0][PIX_W-1:0]  shifted;
    logic [NUM_CH-1:0]             oob;
    logic [NUM_CH-1:0]             active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                mask_reg[c] <= '0;
            end
            shift_set_reg <= '0;
            mode_reg      <= MODE_FOUR;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MASK_CH0:     mask_reg[0]   <= cfg_data;
                REG_MASK_CH1:     mask_reg[1]   <= cfg_data;
                REG_MASK_CH2:     mask_reg[2]   <= cfg_data;
                REG_MASK_CH3:     mask_reg[3]   <= cfg_data;
                REG_SHIFT_SET:    shift_set_reg <= cfg_data[SHIFT_SET_W-1:0];
                REG_CHANNEL_MODE: mode_reg      <= cfg_data[MODE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (mode_reg)
            MODE_ONE: active = 4'b0001;
            MODE_TWO: active = 4'b0011;
            default:  active = 4'b1111;
        endcase
    end

    assign px = pixel & PIX_KEEP;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            shifted[c] = (px & mask_reg[c]) >> shift_set_reg[c*SHIFT_W +: SHIFT_W];
            oob[c]     = shifted[c] >= PIX_W'(TABLE_DEPTH);
        end
    end

    always_comb
    begin
        q_op.is_write = (func_t'(func) == FUNC_WRITE);
        q_op.wr_ok    = 32'(table_index) < 32'(TABLE_DEPTH);
        q_op.wr_sel   = table_select;
        q_op.wr_addr  = TBL_AW'(table_index);
        q_op.wr_value = table_value;
        for (int c = 0; c < NUM_CH; c++)
        begin
            q_op.rd_idx[c] = shifted[c][TBL_AW-1:0];
        end
        q_op.ch_ok = active & ~oob;
        q_op.err   = |(active & oob);
    end

    assign in_stall = q_status.full;
    assign q_push   = in_valid && !q_status.full;

endmodule

/* sv/ppcu_queue.sv */
module ppcu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ppcu_pkg::op_t       push_op,
    input  logic                pop,
    output ppcu_pkg::op_t       head,
    output ppcu_pkg::q_status_t status
);
    import ppcu_pkg::*;

    op_t               entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_op;
        end
    end

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head         = entry[rd_ptr_reg];
    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

/* sv/ppcu_back.sv */
module ppcu_back (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  ppcu_pkg::op_t                                 head,
    input  ppcu_pkg::q_status_t                           q_status,
    output logic                                          q_pop,
    input  logic                                          out_stall,
    output logic                                          out_valid,
    output logic [ppcu_pkg::NUM_CH-1:0][ppcu_pkg::CH_W-1:0] values,
    output logic                                          index_error
);
    import ppcu_pkg::*;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [NUM_CH-1:0] ok_reg;
    logic              err_reg;

    // a new request may leave the queue once the result slot is free or drains
    always_comb
    begin
        q_pop          = !q_status.empty && (!out_valid_reg || !out_stall);
        out_valid_next = out_valid_reg && out_stall;
        if (q_pop)
        begin
            out_valid_next = !head.is_write;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && !head.is_write)
        begin
            ok_reg  <= head.ch_ok;
            err_reg <= head.err;
        end
    end

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_tbl
        logic [CH_W-1:0] mem [TABLE_DEPTH];
        logic [CH_W-1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (q_pop && head.is_write && head.wr_ok && head.wr_sel == SEL_W'(c))
            begin
                mem[head.wr_addr] <= head.wr_value;
            end
            // read data only moves on a pop, so it holds while the output stalls
            if (q_pop && !head.is_write)
            begin
                rd_reg <= mem[head.rd_idx[c]];
            end
        end

        assign values[c] = ok_reg[c] ? rd_reg : '0;
    end

    assign out_valid   = out_valid_reg;
    assign index_error = err_reg;

endmodule

/* sv/packed_pixel_channel_unpacker_core.sv */
// Packed pixel unpacker: each unpack request masks the pixel per channel, shifts it right and
// reads that channel's 16-bit scale table; a table-write request loads one entry and gives no
// result. The block takes one request per clock and keeps that rate as long as results are
// taken; an accepted request is first written into the queue, and its result is registered
// when it leaves the queue. The rate is set by the single port of each 256-entry scale table,
// which serves one read or one write a cycle.
// A four-deep queue sits between the decode front and the table back, so a stalled output
// lets up to four more requests in before in_stall rises. Table contents are not cleared by
// reset; an entry must be written before a pixel reads it.
module packed_pixel_channel_unpacker_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ppcu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppcu_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             func,
    input  logic [ppcu_pkg::PIX_W-1:0]       pixel,
    input  logic [ppcu_pkg::SEL_W-1:0]       table_select,
    input  logic [ppcu_pkg::TIDX_W-1:0]      table_index,
    input  logic [ppcu_pkg::CH_W-1:0]        table_value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ppcu_pkg::CH_W-1:0]        ch0_value,
    output logic [ppcu_pkg::CH_W-1:0]        ch1_value,
    output logic [ppcu_pkg::CH_W-1:0]        ch2_value,
    output logic [ppcu_pkg::CH_W-1:0]        ch3_value,
    output logic                             index_error
);
    import ppcu_pkg::*;

    q_status_t                     q_status;
    logic                          q_push;
    logic                          q_pop;
    op_t                           q_op;
    op_t                           q_head;
    logic [NUM_CH-1:0][CH_W-1:0]   values;

    ppcu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .pixel        (pixel),
        .table_select (table_select),
        .table_index  (table_index),
        .table_value  (table_value),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_op         (q_op)
    );

    ppcu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_op),
        .pop     (q_pop),
        .head    (q_head),
        .status  (q_status)
    );

    ppcu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_status    (q_status),
        .q_pop       (q_pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .values      (values),
        .index_error (index_error)
    );

    assign ch0_value = values[0];
    assign ch1_value = values[1];
    assign ch2_value = values[2];
    assign ch3_value = values[3];

    // a table write never produces a result
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_head.is_write |=> !out_valid)
        else $error("result raised after a table write request");

    // a new result only comes from an unpack request leaving the queue
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(q_pop && !q_head.is_write))
        else $error("result raised without an unpack request");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    // nothing leaves an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> !q_pop)
        else $error("pop from empty queue");

endmodule
